FILE: rtl/sct_pkg.sv
// ============================================================================
// sct_pkg: shared types and constants of the source character tokenizer
// Token kinds, character classes, keyword table, result record and the
// bundle of results that one source character can cause.
// ============================================================================
`default_nettype none

package sct_pkg;

	// token kinds, symbols in table order
	typedef enum logic [4:0] {
		TK_EOF = 5'd0,
		TK_IDENT,
		TK_INT,
		TK_SCORE,
		TK_GLOB,
		TK_CONST,
		TK_IF,
		TK_PLUS,
		TK_MINUS,
		TK_STAR,
		TK_SLASH,
		TK_PERCENT,
		TK_ASSIGN,
		TK_EQ,
		TK_GE,
		TK_LE,
		TK_LPAREN,
		TK_RPAREN,
		TK_LBRACE,
		TK_RBRACE,
		TK_LBRACK,
		TK_RBRACK,
		TK_LT,
		TK_GT,
		TK_SEMI,
		TK_COLON,
		TK_AT,
		TK_COMMA,
		TK_UNKNOWN
	} token_kind_t;

	// lexer mode, one-hot
	typedef enum logic [3:0] {
		M_IDLE  = 4'b0001,
		M_IDENT = 4'b0010,
		M_INT   = 4'b0100,
		M_SYM   = 4'b1000
	} mode_t;

	// keyword table, text left-aligned, zero padded
	localparam int KW_COUNT     = 4;
	localparam int KW_TEXT_LEN  = 5;
	localparam int KW_TEXT_BITS = KW_TEXT_LEN * 8;
	localparam logic [KW_TEXT_BITS-1:0] KW_TEXT [KW_COUNT] = '{
		"score",
		{"glob", 8'h00},
		"const",
		{"if", 24'h000000}
	};
	localparam int KW_LEN [KW_COUNT] = '{5, 4, 5, 2};
	localparam token_kind_t KW_KIND [KW_COUNT] = '{TK_SCORE, TK_GLOB, TK_CONST, TK_IF};

	localparam logic [7:0] CH_NEWLINE    = 8'h0A;
	localparam logic [7:0] CH_UNDERSCORE = "_";
	localparam logic [7:0] CH_EQUAL      = "=";
	localparam logic [7:0] CH_LESS       = "<";
	localparam logic [7:0] CH_GREATER    = ">";

	// results one character can cause: flush, emit, eof
	localparam int RES_SLOTS   = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int OUT_DATA_BITS  = 96;

	typedef struct packed {
		token_kind_t kind;
		logic [15:0] len;
		logic [31:0] val;
		logic        ovf;
		logic [7:0]  bad;
		logic [15:0] line;
		logic [15:0] col;
	} sct_rec_t;

	typedef struct packed {
		sct_rec_t [RES_SLOTS-1:0] rec;
		logic [1:0]               cnt;
	} sct_bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} sct_qstat_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c inside {["a":"z"], ["A":"Z"]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c inside {["0":"9"]});
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c inside {" ", [8'd9:8'd13]});
	endfunction

	function automatic logic is_ident(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE);
	endfunction

	function automatic token_kind_t single_kind(input logic [7:0] c);
		token_kind_t k;
		case (c)
			"+":     k = TK_PLUS;
			"-":     k = TK_MINUS;
			"*":     k = TK_STAR;
			"/":     k = TK_SLASH;
			"%":     k = TK_PERCENT;
			"=":     k = TK_ASSIGN;
			"(":     k = TK_LPAREN;
			")":     k = TK_RPAREN;
			"{":     k = TK_LBRACE;
			"}":     k = TK_RBRACE;
			"[":     k = TK_LBRACK;
			"]":     k = TK_RBRACK;
			"<":     k = TK_LT;
			">":     k = TK_GT;
			";":     k = TK_SEMI;
			":":     k = TK_COLON;
			"@":     k = TK_AT;
			",":     k = TK_COMMA;
			default: k = TK_UNKNOWN;
		endcase
		return k;
	endfunction

	function automatic sct_rec_t make_rec(
		input token_kind_t kind,
		input logic [15:0] len,
		input logic [31:0] val,
		input logic        ovf,
		input logic [7:0]  bad,
		input logic [15:0] line,
		input logic [15:0] col
	);
		sct_rec_t r;
		r.kind = kind;
		r.len  = len;
		r.val  = val;
		r.ovf  = ovf;
		r.bad  = bad;
		r.line = line;
		r.col  = col;
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/sct_front.sv
// ============================================================================
// sct_front: lexer front end
// Takes one character per cycle while the queue has room, advances the lexer
// state, line and column counters, and builds the character's result bundle.
// ============================================================================
`default_nettype none

module sct_front #(
	parameter int KEYWORD_MAX_LEN = 5,
	parameter int VALUE_BITS      = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [15:0]         cfg_wdata,
	input  wire logic                in_valid,
	input  wire logic [7:0]          in_char,
	input  wire logic                in_end,
	output logic                     in_ready,
	input  sct_pkg::sct_qstat_t      q_stat,
	output logic                     push,
	output sct_pkg::sct_bundle_t     push_bundle
);
	import sct_pkg::*;

	// lexer state
	mode_t                  mode_q;
	logic [15:0]            len_q;
	logic [VALUE_BITS-1:0]  acc_q;
	logic                   ovf_q;
	logic [7:0]             pend_q;
	logic [15:0]            start_q;
	logic [15:0]            line_q;
	logic [15:0]            col_q;
	logic [7:0]             pfx_q [KEYWORD_MAX_LEN];

	// after the character, before end of source
	mode_t                  mode_n;
	logic [15:0]            len_n;
	logic [VALUE_BITS-1:0]  acc_n;
	logic                   ovf_n;
	logic [7:0]             pend_n;
	logic [15:0]            line_n;
	logic [15:0]            col_n;
	logic [7:0]             pfx_n [KEYWORD_MAX_LEN];
	logic [KEYWORD_MAX_LEN-1:0] pfx_we;

	// final next state
	mode_t                  mode_f;
	logic [15:0]            line_f;
	logic [15:0]            col_f;

	logic [KW_TEXT_BITS-1:0] view_q;
	logic [KW_TEXT_BITS-1:0] view_n;

	logic                    accept;
	logic                    consumed;
	logic                    va;
	logic                    vb;
	sct_rec_t                rec_a;
	sct_rec_t                rec_b;
	sct_rec_t                rec_e;
	logic [VALUE_BITS+3:0]   acc_wide;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	// prefix views for keyword matching
	for (genvar gi = 0; gi < KW_TEXT_LEN; gi++) begin : g_view
		if (gi < KEYWORD_MAX_LEN) begin : g_used
			assign view_q[gi*8 +: 8] = pfx_q[gi];
			assign view_n[gi*8 +: 8] = pfx_n[gi];
		end else begin : g_pad
			assign view_q[gi*8 +: 8] = 8'd0;
			assign view_n[gi*8 +: 8] = 8'd0;
		end
	end

	for (genvar gp = 0; gp < KEYWORD_MAX_LEN; gp++) begin : g_pfx
		assign pfx_n[gp] = pfx_we[gp] ? in_char : pfx_q[gp];
	end

	function automatic token_kind_t ident_kind(
		input logic [15:0]             len,
		input logic [KW_TEXT_BITS-1:0] view
	);
		token_kind_t kind;
		logic        hit;
		kind = TK_IDENT;
		for (int k = 0; k < KW_COUNT; k++) begin
			hit = (KW_LEN[k] <= KEYWORD_MAX_LEN) && (len == 16'(KW_LEN[k]));
			for (int i = 0; i < KW_TEXT_LEN; i++) begin
				if ((i < KW_LEN[k]) &&
				    (view[i*8 +: 8] != KW_TEXT[k][(KW_TEXT_LEN-1-i)*8 +: 8])) begin
					hit = 1'b0;
				end
			end
			if (hit && (kind == TK_IDENT)) begin
				kind = KW_KIND[k];
			end
		end
		return kind;
	endfunction

	function automatic logic [31:0] fit32(input logic [VALUE_BITS-1:0] acc);
		logic [VALUE_BITS+31:0] w;
		w = {32'd0, acc};
		return w[31:0];
	endfunction

	function automatic sct_rec_t flush_rec(
		input mode_t                   mode,
		input logic [15:0]             len,
		input logic [KW_TEXT_BITS-1:0] view,
		input logic [VALUE_BITS-1:0]   acc,
		input logic                    ovf,
		input logic [7:0]              pend,
		input logic [15:0]             line,
		input logic [15:0]             col
	);
		sct_rec_t r;
		r = make_rec(TK_EOF, 16'd0, 32'd0, 1'b0, 8'd0, line, col);
		case (mode)
			M_IDENT: r = make_rec(ident_kind(len, view), len, 32'd0, 1'b0, 8'd0, line, col);
			M_INT:   r = make_rec(TK_INT, len, fit32(acc), ovf, 8'd0, line, col);
			M_SYM:   r = make_rec(single_kind(pend), 16'd1, 32'd0, 1'b0, 8'd0, line, col);
			default: ;
		endcase
		return r;
	endfunction

	// ten times the accumulator plus the new digit
	assign acc_wide = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
	                + {{VALUE_BITS{1'b0}}, in_char[3:0]};

	// continue or end the current token, then start afresh
	always_comb begin
		mode_n   = mode_q;
		len_n    = len_q;
		acc_n    = acc_q;
		ovf_n    = ovf_q;
		pend_n   = pend_q;
		line_n   = line_q;
		col_n    = col_q;
		pfx_we   = '0;
		consumed = 1'b0;
		va       = 1'b0;
		vb       = 1'b0;
		rec_a    = flush_rec(mode_q, len_q, view_q, acc_q, ovf_q, pend_q, line_q, col_q);
		rec_b    = rec_a;

		case (mode_q)
			M_IDENT: begin
				if (is_ident(in_char)) begin
					for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
						if (len_q == 16'(i)) begin
							pfx_we[i] = 1'b1;
						end
					end
					len_n    = (len_q == 16'hFFFF) ? len_q : len_q + 16'd1;
					col_n    = col_q + 16'd1;
					consumed = 1'b1;
				end else begin
					va     = 1'b1;
					mode_n = M_IDLE;
				end
			end
			M_INT: begin
				if (is_digit(in_char)) begin
					if (ovf_q || (acc_wide[VALUE_BITS+3:VALUE_BITS] != 4'd0)) begin
						acc_n = '1;
						ovf_n = 1'b1;
					end else begin
						acc_n = acc_wide[VALUE_BITS-1:0];
					end
					len_n    = (len_q == 16'hFFFF) ? len_q : len_q + 16'd1;
					col_n    = col_q + 16'd1;
					consumed = 1'b1;
				end else begin
					va     = 1'b1;
					mode_n = M_IDLE;
				end
			end
			M_SYM: begin
				if (in_char == CH_EQUAL) begin
					col_n    = col_q + 16'd1;
					vb       = 1'b1;
					rec_b    = make_rec((pend_q == CH_EQUAL) ? TK_EQ :
					                    ((pend_q == CH_GREATER) ? TK_GE : TK_LE),
					                    16'd2, 32'd0, 1'b0, 8'd0, line_q, col_n);
					mode_n   = M_IDLE;
					consumed = 1'b1;
				end else begin
					va     = 1'b1;
					mode_n = M_IDLE;
				end
			end
			default: ;
		endcase

		// fresh start on this character
		if (!consumed) begin
			if (is_space(in_char)) begin
				if (in_char == CH_NEWLINE) begin
					line_n = line_q + 16'd1;
					col_n  = 16'd0;
				end else begin
					col_n = col_q + 16'd1;
				end
			end else begin
				col_n = col_q + 16'd1;
				if (is_alpha(in_char) || (in_char == CH_UNDERSCORE)) begin
					mode_n    = M_IDENT;
					len_n     = 16'd1;
					pfx_we[0] = 1'b1;
				end else if (is_digit(in_char)) begin
					mode_n = M_INT;
					len_n  = 16'd1;
					acc_n  = {{(VALUE_BITS-4){1'b0}}, in_char[3:0]};
					ovf_n  = 1'b0;
				end else if ((in_char == CH_EQUAL) || (in_char == CH_LESS) ||
				             (in_char == CH_GREATER)) begin
					mode_n = M_SYM;
					pend_n = in_char;
				end else begin
					vb    = 1'b1;
					rec_b = make_rec(single_kind(in_char), 16'd1, 32'd0, 1'b0,
					                 (single_kind(in_char) == TK_UNKNOWN) ? in_char : 8'd0,
					                 line_q, col_n);
				end
			end
		end
	end

	// end of source: flush what is left, then eof
	always_comb begin
		mode_f = mode_n;
		line_f = line_n;
		col_f  = col_n;
		rec_e  = make_rec(TK_EOF, 16'd0, 32'd0, 1'b0, 8'd0, line_n, col_n);
		push_bundle.rec[0] = rec_e;
		push_bundle.rec[1] = rec_e;
		push_bundle.rec[2] = rec_e;
		if (in_end) begin
			mode_f = M_IDLE;
			line_f = start_q;
			col_f  = 16'd0;
		end

		// compact the bundle, results in order
		if (va) begin
			push_bundle.rec[0] = rec_a;
			if (vb) begin
				push_bundle.rec[1] = rec_b;
			end else if (in_end && (mode_n != M_IDLE)) begin
				push_bundle.rec[1] = flush_rec(mode_n, len_n, view_n, acc_n, ovf_n,
				                               pend_n, line_n, col_n);
			end
		end else if (vb) begin
			push_bundle.rec[0] = rec_b;
		end else if (in_end && (mode_n != M_IDLE)) begin
			push_bundle.rec[0] = flush_rec(mode_n, len_n, view_n, acc_n, ovf_n,
			                               pend_n, line_n, col_n);
		end
		push_bundle.cnt = {1'b0, va} + {1'b0, vb || (in_end && (mode_n != M_IDLE))}
		                + {1'b0, in_end};
	end

	assign push = accept && (va || vb || in_end);

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			len_q   <= 16'd0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			pend_q  <= 8'd0;
			start_q <= 16'd1;
			line_q  <= 16'd1;
			col_q   <= 16'd0;
		end else begin
			if (accept) begin
				mode_q <= mode_f;
				len_q  <= len_n;
				acc_q  <= acc_n;
				ovf_q  <= ovf_n;
				pend_q <= pend_n;
				line_q <= line_f;
				col_q  <= col_f;
			end
			if (cfg_we) begin
				start_q <= cfg_wdata;
				line_q  <= cfg_wdata;
			end
		end
	end

	// identifier prefix, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
				pfx_q[i] <= pfx_n[i];
			end
		end
	end

	// end of source leaves the lexer idle at column zero
	a_eof_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_end |=> (mode_q == M_IDLE) && (col_q == 16'd0))
		else $error("lexer not idle after end of source");

	// end of source always produces at least the eof result
	a_eof_push: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_end |-> push && (push_bundle.cnt != 2'd0))
		else $error("end of source without eof result");

endmodule

`default_nettype wire

FILE: rtl/sct_queue.sv
// ============================================================================
// sct_queue: result bundle queue
// Short queue of result bundles between the lexer front end and the output
// serialiser, so that either side can stall on its own.
// ============================================================================
`default_nettype none

module sct_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  sct_pkg::sct_bundle_t     push_bundle,
	input  wire logic                pop,
	output sct_pkg::sct_bundle_t     head,
	output sct_pkg::sct_qstat_t      stat
);
	import sct_pkg::*;

	sct_bundle_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_PTR_BITS:0]   count_q;

	assign stat.full  = (count_q == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_bundle;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full || pop)
		else $error("push into full queue");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("pop from empty queue");

	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH))
		else $error("queue level beyond depth");

endmodule

`default_nettype wire

FILE: rtl/sct_back.sv
// ============================================================================
// sct_back: output serialiser
// Hands out the head bundle's results one per cycle while out_ready is high,
// through an output register, and retires the bundle after its last result.
// ============================================================================
`default_nettype none

module sct_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  sct_pkg::sct_bundle_t     head,
	input  sct_pkg::sct_qstat_t      q_stat,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output sct_pkg::sct_rec_t        out_rec,
	output logic                     out_last
);
	import sct_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	logic       last_q;
	sct_rec_t   rec_q;
	logic       load;
	logic       is_last;

	assign load    = !q_stat.empty && (!valid_q || out_ready);
	assign is_last = (idx_q == (head.cnt - 2'd1));
	assign pop     = load && is_last;

	assign out_valid = valid_q;
	assign out_rec   = rec_q;
	assign out_last  = last_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			rec_q  <= head.rec[idx_q];
			last_q <= is_last;
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		!q_stat.empty |-> (idx_q < head.cnt))
		else $error("result index beyond bundle count");

endmodule

`default_nettype wire

FILE: rtl/source_char_tokenizer_core.sv
// ============================================================================
// source_char_tokenizer_core: streaming source tokenizer
// One source character in per request, tokens with position out, longest
// symbol match, saturating integer literals and keyword recognition.
// ============================================================================
// Usage
//  - slave side: one source character per request in s_tdata, s_tlast set on
//    the final character of a source text
//  - master side: one token per request, kind in m_tuser, m_tlast on the last
//    token that a character causes; a character causes zero to three tokens
//  - cfg_we/cfg_wdata write the start line, which also loads the line counter;
//    write only while no tokens are outstanding
//  - the first token of a character is written into the bundle queue and then
//    loaded into the output register, from which the master side shows it
//  - throughput: one character per cycle on the input while the four-entry
//    bundle queue has room; the output register hands out one token per
//    cycle while m_tready is high; a stalled master side fills the queue,
//    after which s_tready drops; no token is lost or repeated
//  - reset: lexer idle, line counter 1, column 0, queue and output empty
// ============================================================================
`default_nettype none

module source_char_tokenizer_core #(
	parameter int KEYWORD_MAX_LEN = 5,
	parameter int VALUE_BITS      = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // source_char
	input  wire logic        s_tlast,   // end_of_source
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [sct_pkg::OUT_DATA_BITS-1:0] m_tdata, // token_length, int_value,
	                                    // int_overflow, bad_char, line_number,
	                                    // column_number, zero pad
	output logic [4:0]       m_tuser,   // token_kind
	output logic             m_tlast    // last_of_run
);
	import sct_pkg::*;

	sct_qstat_t  q_stat;
	logic        push;
	logic        pop;
	sct_bundle_t push_bundle;
	sct_bundle_t head;
	sct_rec_t    out_rec;

	// front end: lexer
	sct_front #(
		.KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
		.VALUE_BITS      (VALUE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (s_tvalid),
		.in_char     (s_tdata),
		.in_end      (s_tlast),
		.in_ready    (s_tready),
		.q_stat      (q_stat),
		.push        (push),
		.push_bundle (push_bundle)
	);

	// bundle queue
	sct_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_bundle (push_bundle),
		.pop         (pop),
		.head        (head),
		.stat        (q_stat)
	);

	// back end: serialiser
	sct_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_rec   (out_rec),
		.out_last  (m_tlast)
	);

	// output packing
	assign m_tdata = {7'd0, out_rec.col, out_rec.line, out_rec.bad, out_rec.ovf,
	                  out_rec.val, out_rec.len};
	assign m_tuser = out_rec.kind;

endmodule

`default_nettype wire
